// ===== sv/assert_macros.svh =====
// Assertion helpers for the neighbor cache. Every user has clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define NCR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("neighbor cache assertion failed");

// Condition that must never be seen.
`define NCR_ASSERT_NEVER(lbl, cond) `NCR_ASSERT(lbl, !(cond))

`endif

// ===== sv/ncr_pkg.sv =====
package ncr_pkg;

  localparam int unsigned ENTRIES_DEF = 16;
  localparam int unsigned ADDR_W      = 5;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned IP_W        = 32;
  localparam int unsigned MAC_W       = 48;
  localparam int unsigned TS_W        = 32;

  localparam logic OP_RESOLVE = 1'b0;
  localparam logic OP_LEARN   = 1'b1;

  localparam logic [1:0] KIND_LEARNED = 2'd0;
  localparam logic [1:0] KIND_PROBING = 2'd1;
  localparam logic [1:0] KIND_PENDING = 2'd2;

  localparam logic [2:0] REG_OUR_IP        = 3'd0;
  localparam logic [2:0] REG_PREFIX_LEN    = 3'd1;
  localparam logic [2:0] REG_GATEWAY_IP    = 3'd2;
  localparam logic [2:0] REG_STALE_MS      = 3'd3;
  localparam logic [2:0] REG_PROBE_TIMEOUT = 3'd4;
  localparam logic [2:0] REG_RETRY_MS      = 3'd5;

  localparam logic [IP_W-1:0] OUR_IP_RST     = 32'd0;
  localparam logic [5:0]      PREFIX_LEN_RST = 6'd24;
  localparam logic [IP_W-1:0] GATEWAY_RST    = 32'd0;
  localparam logic [TS_W-1:0] STALE_RST      = 32'd60000;
  localparam logic [TS_W-1:0] PROBE_RST      = 32'd3000;
  localparam logic [TS_W-1:0] RETRY_RST      = 32'd1000;
  localparam logic [5:0]      PREFIX_MAX     = 6'd32;

  localparam logic [MAC_W-1:0] MAC_BCAST = {MAC_W{1'b1}};

  typedef enum logic [2:0] {
    ST_FRESH     = 3'd0,
    ST_STALE     = 3'd1,
    ST_PROBING   = 3'd2,
    ST_EVICTED   = 3'd3,
    ST_MISS_SENT = 3'd4,
    ST_THROTTLED = 3'd5,
    ST_SHORT     = 3'd6,
    ST_LEARNED   = 3'd7
  } status_e;

  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
    logic [1:0]       kind;
    logic [TS_W-1:0]  tstamp;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [IP_W-1:0] our_ip;
    logic [5:0]      prefix_len;
    logic [IP_W-1:0] gateway_ip;
    logic [TS_W-1:0] stale_ms;
    logic [TS_W-1:0] probe_timeout_ms;
    logic [TS_W-1:0] retry_ms;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic scan;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
  } dp_sts_t;

endpackage

// ===== sv/ncr_ram.sv =====
module ncr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/ncr_regs.sv =====
module ncr_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel_i,
  input  logic                      penable_i,
  input  logic                      pwrite_i,
  input  logic [ncr_pkg::ADDR_W-1:0] paddr_i,
  input  logic [ncr_pkg::DATA_W-1:0] pwdata_i,
  output logic [ncr_pkg::DATA_W-1:0] prdata_o,
  output ncr_pkg::cfg_t             cfg_o
);

  ncr_pkg::cfg_t cfg_q;
  logic [2:0]    reg_idx;

  assign reg_idx = paddr_i[ncr_pkg::ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.our_ip           <= ncr_pkg::OUR_IP_RST;
      cfg_q.prefix_len       <= ncr_pkg::PREFIX_LEN_RST;
      cfg_q.gateway_ip       <= ncr_pkg::GATEWAY_RST;
      cfg_q.stale_ms         <= ncr_pkg::STALE_RST;
      cfg_q.probe_timeout_ms <= ncr_pkg::PROBE_RST;
      cfg_q.retry_ms         <= ncr_pkg::RETRY_RST;
    end else if (psel_i && penable_i && pwrite_i) begin
      unique case (reg_idx)
        ncr_pkg::REG_OUR_IP:        cfg_q.our_ip           <= pwdata_i;
        ncr_pkg::REG_PREFIX_LEN:    cfg_q.prefix_len       <= pwdata_i[5:0];
        ncr_pkg::REG_GATEWAY_IP:    cfg_q.gateway_ip       <= pwdata_i;
        ncr_pkg::REG_STALE_MS:      cfg_q.stale_ms         <= pwdata_i;
        ncr_pkg::REG_PROBE_TIMEOUT: cfg_q.probe_timeout_ms <= pwdata_i;
        ncr_pkg::REG_RETRY_MS:      cfg_q.retry_ms         <= pwdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ncr_pkg::REG_OUR_IP:        prdata_o = cfg_q.our_ip;
      ncr_pkg::REG_PREFIX_LEN:    prdata_o = {26'd0, cfg_q.prefix_len};
      ncr_pkg::REG_GATEWAY_IP:    prdata_o = cfg_q.gateway_ip;
      ncr_pkg::REG_STALE_MS:      prdata_o = cfg_q.stale_ms;
      ncr_pkg::REG_PROBE_TIMEOUT: prdata_o = cfg_q.probe_timeout_ms;
      ncr_pkg::REG_RETRY_MS:      prdata_o = cfg_q.retry_ms;
      default:                    prdata_o = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/ncr_dp.sv =====
module ncr_dp #(
  parameter int unsigned ENTRIES = ncr_pkg::ENTRIES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ncr_pkg::cfg_t               cfg_i,
  input  ncr_pkg::ctrl_cmd_t          cmd_i,
  output ncr_pkg::dp_sts_t            sts_o,
  input  logic                        opcode_i,
  input  logic [ncr_pkg::TS_W-1:0]    now_ms_i,
  input  logic [ncr_pkg::IP_W-1:0]    ip_addr_i,
  input  logic [ncr_pkg::MAC_W-1:0]   mac_addr_i,
  input  logic                        header_short_i,
  output logic [ncr_pkg::MAC_W-1:0]   dst_mac_o,
  output logic                        send_request_o,
  output logic [ncr_pkg::IP_W-1:0]    request_ip_o,
  output logic [2:0]                  status_o
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

  // item registers
  logic                      op_q, short_q;
  logic [ncr_pkg::TS_W-1:0]  now_q;
  logic [ncr_pkg::MAC_W-1:0] mac_q;
  logic [ncr_pkg::IP_W-1:0]  key_q, key_d;

  // scan state
  logic [IDX_W-1:0]   idx_q, rd_idx_q;
  logic               rd_vld_q;
  logic               hit_q, free_q;
  logic [IDX_W-1:0]   hit_idx_q, free_idx_q;
  ncr_pkg::entry_t    entry_q, rd_entry;
  logic [ENTRIES-1:0] used_q;
  logic [IDX_W-1:0]   victim_q, victim_next;
  logic               cur_used, cur_match;

  // commit path
  logic [ncr_pkg::TS_W-1:0]  age;
  logic [IDX_W-1:0]          alloc_idx, wr_slot;
  logic                      wr_en, adv_victim;
  ncr_pkg::entry_t           wr_data;
  logic [ncr_pkg::MAC_W-1:0] res_mac;
  logic                      res_send;
  logic [ncr_pkg::IP_W-1:0]  res_ip;
  ncr_pkg::status_e          res_status;

  logic [ncr_pkg::MAC_W-1:0] dst_mac_q;
  logic                      send_q;
  logic [ncr_pkg::IP_W-1:0]  rip_q;
  logic [2:0]                status_q;

  logic [5:0]               plen;
  logic [ncr_pkg::IP_W-1:0] mask, hop;

  // next hop: destination when on our subnet, else the gateway
  always_comb begin
    plen = (cfg_i.prefix_len > ncr_pkg::PREFIX_MAX) ? ncr_pkg::PREFIX_MAX : cfg_i.prefix_len;
    mask = ~({ncr_pkg::IP_W{1'b1}} >> plen);
    hop  = ((ip_addr_i & mask) == (cfg_i.our_ip & mask)) ? ip_addr_i : cfg_i.gateway_ip;
    key_d = (opcode_i == ncr_pkg::OP_LEARN) ? ip_addr_i : hop;
  end

  ncr_ram #(
    .WIDTH(ncr_pkg::ENTRY_W),
    .DEPTH(ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (cmd_i.commit && wr_en),
    .waddr_i(wr_slot),
    .wdata_i(wr_data),
    .re_i   (cmd_i.scan),
    .raddr_i(idx_q),
    .rdata_o(rd_entry)
  );

  assign cur_used  = used_q[rd_idx_q];
  assign cur_match = rd_vld_q && cur_used && (rd_entry.ip == key_q);

  assign sts_o.scan_last = (idx_q == IDX_LAST);

  assign alloc_idx   = free_q ? free_idx_q : victim_q;
  assign victim_next = (victim_q == IDX_LAST) ? '0 : victim_q + 1'b1;
  assign age         = now_q - entry_q.tstamp;

  always_comb begin
    wr_en          = 1'b0;
    adv_victim     = 1'b0;
    wr_slot        = alloc_idx;
    wr_data.ip     = key_q;
    wr_data.mac    = '0;
    wr_data.kind   = ncr_pkg::KIND_PENDING;
    wr_data.tstamp = now_q;
    res_mac        = ncr_pkg::MAC_BCAST;
    res_send       = 1'b0;
    res_ip         = key_q;
    res_status     = ncr_pkg::ST_MISS_SENT;
    if (op_q == ncr_pkg::OP_LEARN) begin
      wr_en        = 1'b1;
      wr_slot      = hit_q ? hit_idx_q : alloc_idx;
      adv_victim   = !hit_q && !free_q;
      wr_data.mac  = mac_q;
      wr_data.kind = ncr_pkg::KIND_LEARNED;
      res_mac      = '0;
      res_ip       = '0;
      res_status   = ncr_pkg::ST_LEARNED;
    end else if (short_q) begin
      res_ip     = '0;
      res_status = ncr_pkg::ST_SHORT;
    end else if (hit_q) begin
      wr_slot        = hit_idx_q;
      wr_data        = entry_q;
      wr_data.tstamp = now_q;
      unique case (entry_q.kind)
        ncr_pkg::KIND_LEARNED: begin
          res_mac = entry_q.mac;
          if (age >= cfg_i.stale_ms) begin
            wr_en        = 1'b1;
            wr_data.kind = ncr_pkg::KIND_PROBING;
            res_send     = 1'b1;
            res_status   = ncr_pkg::ST_STALE;
          end else begin
            res_status = ncr_pkg::ST_FRESH;
          end
        end
        ncr_pkg::KIND_PROBING: begin
          if (age < cfg_i.probe_timeout_ms) begin
            res_mac    = entry_q.mac;
            res_status = ncr_pkg::ST_PROBING;
          end else begin
            wr_en        = 1'b1;
            wr_data.kind = ncr_pkg::KIND_PENDING;
            res_send     = 1'b1;
            res_status   = ncr_pkg::ST_EVICTED;
          end
        end
        default: begin
          // pending, or a kind code with no meaning
          if (age > cfg_i.retry_ms) begin
            wr_en        = 1'b1;
            wr_data.kind = ncr_pkg::KIND_PENDING;
            res_send     = 1'b1;
            res_status   = ncr_pkg::ST_MISS_SENT;
          end else begin
            res_status = ncr_pkg::ST_THROTTLED;
          end
        end
      endcase
    end else begin
      wr_en      = 1'b1;
      adv_victim = !free_q;
      res_send   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
      used_q   <= '0;
      victim_q <= '0;
    end else begin
      rd_vld_q <= cmd_i.scan;
      if (cmd_i.capture) begin
        idx_q  <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else begin
        if (cmd_i.scan) begin
          idx_q <= sts_o.scan_last ? '0 : idx_q + 1'b1;
        end
        if (cur_match && !hit_q) begin
          hit_q <= 1'b1;
        end
        if (rd_vld_q && !cur_used && !free_q) begin
          free_q <= 1'b1;
        end
      end
      if (cmd_i.commit && wr_en) begin
        used_q[wr_slot] <= 1'b1;
      end
      if (cmd_i.commit && adv_victim) begin
        victim_q <= victim_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= opcode_i;
      short_q <= header_short_i;
      now_q   <= now_ms_i;
      mac_q   <= mac_addr_i;
      key_q   <= key_d;
    end
    if (cmd_i.scan) begin
      rd_idx_q <= idx_q;
    end
    if (cur_match && !hit_q) begin
      hit_idx_q <= rd_idx_q;
      entry_q   <= rd_entry;
    end
    if (rd_vld_q && !cur_used && !free_q) begin
      free_idx_q <= rd_idx_q;
    end
    if (cmd_i.commit) begin
      dst_mac_q <= res_mac;
      send_q    <= res_send;
      rip_q     <= res_ip;
      status_q  <= res_status;
    end
  end

  assign dst_mac_o      = dst_mac_q;
  assign send_request_o = send_q;
  assign request_ip_o   = rip_q;
  assign status_o       = status_q;

endmodule

// ===== sv/ncr_ctrl.sv =====
`include "assert_macros.svh"

module ncr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ncr_pkg::ctrl_cmd_t cmd_o,
  input  ncr_pkg::dp_sts_t   sts_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o.capture = (state_q == S_IDLE) && in_valid_i;
    cmd_o.scan    = (state_q == S_SCAN);
    cmd_o.commit  = (state_q == S_COMMIT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // a commit refills the output register in the cycle it is taken
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (sts_i.scan_last) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // last table word is compared here
          state_q <= S_COMMIT;
        end
        S_COMMIT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

  `NCR_ASSERT(a_no_overwrite, cmd_o.commit |-> (!out_valid_q || out_ready_i))
  `NCR_ASSERT(a_valid_from_commit, $rose(out_valid_q) |-> $past(cmd_o.commit))
  `NCR_ASSERT(a_drain_after_last, (state_q == S_DRAIN) |-> $past(sts_i.scan_last))
  `NCR_ASSERT_NEVER(a_capture_busy, cmd_o.capture && (cmd_o.scan || cmd_o.commit))

endmodule

// ===== sv/neighbor_cache_resolver.sv =====
// Neighbor (ARP) cache with aging, probing and rate-limited requests.
// Input channel (in_valid_i / in_ready_o): one item per lookup or learn;
// opcode_i selects resolve or learn, now_ms_i is a wrapping ms timestamp.
// Output channel (out_valid_o / out_ready_i): exactly one result per item,
// in order: next-hop MAC or broadcast, request flag, next-hop IP and status.
// Configuration: APB port, registers at byte offsets 0x00..0x14, pready tied
// high; the user must write them only while the block is idle (unenforced).
// Sequencing: every item walks the whole table through the one read port of
// the table RAM, one entry per cycle, then commits; a new item is accepted
// only after the previous one has committed.
// The finished result sits in an output register; the next item is accepted
// and scanned while it waits. If the receiver stalls, the following item
// holds before its commit until the output register is taken.
// Reset: table empty (all entries invalid), victim pointer zero, registers
// at their defaults; no clearing pass is needed.
module neighbor_cache_resolver #(
  parameter int unsigned ENTRIES = ncr_pkg::ENTRIES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ncr_pkg::ADDR_W-1:0]  paddr,
  input  logic [ncr_pkg::DATA_W-1:0]  pwdata,
  output logic [ncr_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        opcode_i,
  input  logic [ncr_pkg::TS_W-1:0]    now_ms_i,
  input  logic [ncr_pkg::IP_W-1:0]    ip_addr_i,
  input  logic [ncr_pkg::MAC_W-1:0]   mac_addr_i,
  input  logic                        header_short_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ncr_pkg::MAC_W-1:0]   dst_mac_o,
  output logic                        send_request_o,
  output logic [ncr_pkg::IP_W-1:0]    request_ip_o,
  output logic [2:0]                  status_o
);

  ncr_pkg::cfg_t      cfg;
  ncr_pkg::ctrl_cmd_t cmd;
  ncr_pkg::dp_sts_t   sts;

  assign pready = 1'b1;

  ncr_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel_i   (psel),
    .penable_i(penable),
    .pwrite_i (pwrite),
    .paddr_i  (paddr),
    .pwdata_i (pwdata),
    .prdata_o (prdata),
    .cfg_o    (cfg)
  );

  ncr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  ncr_dp #(
    .ENTRIES(ENTRIES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .opcode_i      (opcode_i),
    .now_ms_i      (now_ms_i),
    .ip_addr_i     (ip_addr_i),
    .mac_addr_i    (mac_addr_i),
    .header_short_i(header_short_i),
    .dst_mac_o     (dst_mac_o),
    .send_request_o(send_request_o),
    .request_ip_o  (request_ip_o),
    .status_o      (status_o)
  );

endmodule
